@@ design/aik_pkg.sv @@
// Shared types, constants and arithmetic helpers for the arm cost gradient kernel.
package aik_pkg;

  localparam int WIDE_W           = 34;
  localparam int CORDIC_ITER_DEF  = 16;
  localparam int CORDIC_ITER_MAX  = 24;

  typedef logic signed [35:0]       ang_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam ang_t ANG_PI      = 36'sd3373259426;
  localparam ang_t ANG_TWO_PI  = 36'sd6746518852;
  localparam ang_t ANG_HALF_PI = 36'sd1686629713;
  localparam ang_t CORDIC_GAIN = 36'sd652032874;

  localparam logic [15:0] UPPER_ARM_RST = 16'd8126;
  localparam logic [15:0] FOREARM_RST   = 16'd8126;
  localparam logic [15:0] WRIST_RST     = 16'd8258;
  localparam logic [15:0] BASE_H_RST    = 16'd5046;

  typedef enum logic [1:0] {
    REG_UPPER_ARM = 2'd0,
    REG_FOREARM   = 2'd1,
    REG_WRIST     = 2'd2,
    REG_BASE_H    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic signed [16:0] z;
  } tgt_t;

  // Position plus the partials of the position for joints 2 to 4, all Q24.
  typedef struct packed {
    wide_t fx;
    wide_t fy;
    wide_t fz;
    wide_t gx2;
    wide_t gy2;
    wide_t gx3;
    wide_t gy3;
    wide_t gx4;
    wide_t gy4;
    wide_t gz2;
    wide_t gz3;
    wide_t gz4;
  } kin_t;

  function automatic ang_t atan_f(input int i);
    ang_t v;
    case (i)
      0:  v = 36'sh03243F6A8;
      1:  v = 36'sh01DAC6705;
      2:  v = 36'sh00FADBAFC;
      3:  v = 36'sh007F56EA6;
      4:  v = 36'sh003FEAB76;
      5:  v = 36'sh001FFD55B;
      6:  v = 36'sh000FFFAAA;
      7:  v = 36'sh0007FFF55;
      8:  v = 36'sh0003FFFEA;
      9:  v = 36'sh0001FFFFD;
      10: v = 36'sh0000FFFFF;
      11: v = 36'sh00007FFFF;
      12: v = 36'sh00003FFFF;
      13: v = 36'sh00001FFFF;
      14: v = 36'sh00000FFFF;
      15: v = 36'sh000007FFF;
      16: v = 36'sh000003FFF;
      17: v = 36'sh000001FFF;
      18: v = 36'sh000000FFF;
      19: v = 36'sh0000007FF;
      20: v = 36'sh0000003FF;
      21: v = 36'sh0000001FF;
      22: v = 36'sh0000000FF;
      23: v = 36'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q24 by Q24 product, floored back to Q24.
  function automatic wide_t mul24(input wide_t a, input wide_t b);
    logic signed [2*WIDE_W-1:0] p;
    p = a * b;
    return p[WIDE_W+23:24];
  endfunction

endpackage

@@ design/aik_angle.sv @@
// Angle range reduction: wrap into [-pi, pi), then fold into [-pi/2, pi/2].
module aik_angle (
  input  logic               clk,
  input  logic               en,
  input  aik_pkg::ang_t      a_i,
  output aik_pkg::ang_t      z_o,
  output logic               neg_o
);

  aik_pkg::ang_t w1, w2, w_r, z_nxt, z_r;
  logic          neg_nxt, neg_r;

  // Two wrap steps cover the widest sum of three joints.
  always_comb begin
    if (a_i >= aik_pkg::ANG_PI) begin
      w1 = a_i - aik_pkg::ANG_TWO_PI;
    end else if (a_i < -aik_pkg::ANG_PI) begin
      w1 = a_i + aik_pkg::ANG_TWO_PI;
    end else begin
      w1 = a_i;
    end
    if (w1 >= aik_pkg::ANG_PI) begin
      w2 = w1 - aik_pkg::ANG_TWO_PI;
    end else if (w1 < -aik_pkg::ANG_PI) begin
      w2 = w1 + aik_pkg::ANG_TWO_PI;
    end else begin
      w2 = w1;
    end
  end

  always_comb begin
    if (w_r > aik_pkg::ANG_HALF_PI) begin
      z_nxt   = w_r - aik_pkg::ANG_PI;
      neg_nxt = 1'b1;
    end else if (w_r < -aik_pkg::ANG_HALF_PI) begin
      z_nxt   = w_r + aik_pkg::ANG_PI;
      neg_nxt = 1'b1;
    end else begin
      z_nxt   = w_r;
      neg_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r   <= w2;
      z_r   <= z_nxt;
      neg_r <= neg_nxt;
    end
  end

  assign z_o   = z_r;
  assign neg_o = neg_r;

endmodule

@@ design/aik_cordic.sv @@
// Pipelined rotation-mode CORDIC: one micro-rotation per stage, Q24 sine and cosine out.
module aik_cordic #(
  parameter int NI = aik_pkg::CORDIC_ITER_DEF
) (
  input  logic           clk,
  input  logic           en,
  input  aik_pkg::ang_t  z_i,
  input  logic           neg_i,
  output aik_pkg::wide_t sin_o,
  output aik_pkg::wide_t cos_o
);

  aik_pkg::ang_t  x_r [NI];
  aik_pkg::ang_t  y_r [NI];
  aik_pkg::ang_t  z_r [NI];
  logic           n_r [NI];
  aik_pkg::ang_t  xf, yf, xs, ys;
  aik_pkg::wide_t sin_r, cos_r;

  for (genvar i = 0; i < NI; i++) begin : g_stage
    aik_pkg::ang_t xi, yi, zi;
    logic          ni;
    if (i == 0) begin : g_first
      assign xi = aik_pkg::CORDIC_GAIN;
      assign yi = '0;
      assign zi = z_i;
      assign ni = neg_i;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign ni = n_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[35]) begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - aik_pkg::atan_f(i);
        end else begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + aik_pkg::atan_f(i);
        end
        n_r[i] <= ni;
      end
    end
  end

  // Undo the fold, then drop to Q24.
  always_comb begin
    xf = n_r[NI-1] ? -x_r[NI-1] : x_r[NI-1];
    yf = n_r[NI-1] ? -y_r[NI-1] : y_r[NI-1];
    xs = xf >>> 6;
    ys = yf >>> 6;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= xs[aik_pkg::WIDE_W-1:0];
      sin_r <= ys[aik_pkg::WIDE_W-1:0];
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

@@ design/aik_kin.sv @@
// Forward kinematics and position partials, three register stages.
module aik_kin (
  input  logic           clk,
  input  logic           en,
  input  logic [15:0]    l2,
  input  logic [15:0]    l3,
  input  logic [15:0]    l4,
  input  logic [15:0]    hb,
  input  aik_pkg::wide_t s1,
  input  aik_pkg::wide_t c1,
  input  aik_pkg::wide_t s2,
  input  aik_pkg::wide_t c2,
  input  aik_pkg::wide_t s23,
  input  aik_pkg::wide_t c23,
  input  aik_pkg::wide_t s234,
  input  aik_pkg::wide_t c234,
  output aik_pkg::kin_t  k_o
);

  aik_pkg::wide_t l2w, l3w, l4w, hbw;
  aik_pkg::wide_t a2c_r, a3c_r, a4c_r, a2s_r, a3s_r, a4s_r, c1a_r, s1a_r;
  aik_pkg::wide_t r_r, h_r, p3_r, z3_r, p4_r, z4_r, c1b_r, s1b_r;
  aik_pkg::kin_t  k_r;

  assign l2w = {10'd0, l2, 8'd0};
  assign l3w = {10'd0, l3, 8'd0};
  assign l4w = {10'd0, l4, 8'd0};
  assign hbw = {10'd0, hb, 8'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      a2c_r <= aik_pkg::mul24(l2w, c2);
      a3c_r <= aik_pkg::mul24(l3w, c23);
      a4c_r <= aik_pkg::mul24(l4w, c234);
      a2s_r <= aik_pkg::mul24(l2w, s2);
      a3s_r <= aik_pkg::mul24(l3w, s23);
      a4s_r <= aik_pkg::mul24(l4w, s234);
      c1a_r <= c1;
      s1a_r <= s1;

      r_r   <= a4c_r + a3c_r + a2c_r;
      h_r   <= a4s_r + a3s_r + a2s_r;
      p3_r  <= -(a4s_r + a3s_r);
      z3_r  <= a4c_r + a3c_r;
      p4_r  <= -a4s_r;
      z4_r  <= a4c_r;
      c1b_r <= c1a_r;
      s1b_r <= s1a_r;

      k_r.fx  <= aik_pkg::mul24(c1b_r, r_r);
      k_r.fy  <= aik_pkg::mul24(s1b_r, r_r);
      k_r.fz  <= hbw + h_r;
      k_r.gx2 <= aik_pkg::mul24(c1b_r, -h_r);
      k_r.gy2 <= aik_pkg::mul24(s1b_r, -h_r);
      k_r.gx3 <= aik_pkg::mul24(c1b_r, p3_r);
      k_r.gy3 <= aik_pkg::mul24(s1b_r, p3_r);
      k_r.gx4 <= aik_pkg::mul24(c1b_r, p4_r);
      k_r.gy4 <= aik_pkg::mul24(s1b_r, p4_r);
      k_r.gz2 <= r_r;
      k_r.gz3 <= z3_r;
      k_r.gz4 <= z4_r;
    end
  end

  assign k_o = k_r;

endmodule

@@ design/aik_cost.sv @@
// Error to target, cost and gradients, with saturation into the output register.
module aik_cost (
  input  logic                clk,
  input  logic                en,
  input  aik_pkg::kin_t       k_i,
  input  aik_pkg::tgt_t       t_i,
  output logic signed [16:0]  pos_x,
  output logic signed [16:0]  pos_y,
  output logic signed [16:0]  pos_z,
  output logic [18:0]         cost,
  output logic signed [19:0]  grad_1,
  output logic signed [19:0]  grad_2,
  output logic signed [19:0]  grad_3,
  output logic signed [19:0]  grad_4
);

  aik_pkg::wide_t tx, ty, tz;
  aik_pkg::wide_t dx_r, dy_r, dz_r;
  aik_pkg::kin_t  k_r;
  aik_pkg::wide_t fx_r, fy_r, fz_r;
  aik_pkg::wide_t qx_r, qy_r, qz_r;
  aik_pkg::wide_t g1x_r, g1y_r, g2x_r, g2y_r, g2z_r;
  aik_pkg::wide_t g3x_r, g3y_r, g3z_r, g4x_r, g4y_r, g4z_r;
  aik_pkg::wide_t px, py, pz, cs, g1, g2, g3, g4;
  logic signed [16:0] pos_x_r, pos_y_r, pos_z_r;
  logic [18:0]        cost_r;
  logic signed [19:0] grad_1_r, grad_2_r, grad_3_r, grad_4_r;

  function automatic logic signed [16:0] sat_pos(input aik_pkg::wide_t v);
    if (v > 34'sd65535) begin
      return 17'sd65535;
    end else if (v < -34'sd65536) begin
      return -17'sd65536;
    end
    return v[16:0];
  endfunction

  function automatic logic signed [19:0] sat_grad(input aik_pkg::wide_t v);
    if (v > 34'sd524287) begin
      return 20'sd524287;
    end else if (v < -34'sd524288) begin
      return -20'sd524288;
    end
    return v[19:0];
  endfunction

  assign tx = {{9{t_i.x[16]}}, t_i.x, 8'd0};
  assign ty = {{9{t_i.y[16]}}, t_i.y, 8'd0};
  assign tz = {{9{t_i.z[16]}}, t_i.z, 8'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= k_i.fx - tx;
      dy_r  <= k_i.fy - ty;
      dz_r  <= k_i.fz - tz;
      k_r   <= k_i;

      fx_r  <= k_r.fx;
      fy_r  <= k_r.fy;
      fz_r  <= k_r.fz;
      qx_r  <= aik_pkg::mul24(dx_r, dx_r);
      qy_r  <= aik_pkg::mul24(dy_r, dy_r);
      qz_r  <= aik_pkg::mul24(dz_r, dz_r);
      g1x_r <= aik_pkg::mul24(dx_r, -k_r.fy);
      g1y_r <= aik_pkg::mul24(dy_r, k_r.fx);
      g2x_r <= aik_pkg::mul24(dx_r, k_r.gx2);
      g2y_r <= aik_pkg::mul24(dy_r, k_r.gy2);
      g2z_r <= aik_pkg::mul24(dz_r, k_r.gz2);
      g3x_r <= aik_pkg::mul24(dx_r, k_r.gx3);
      g3y_r <= aik_pkg::mul24(dy_r, k_r.gy3);
      g3z_r <= aik_pkg::mul24(dz_r, k_r.gz3);
      g4x_r <= aik_pkg::mul24(dx_r, k_r.gx4);
      g4y_r <= aik_pkg::mul24(dy_r, k_r.gy4);
      g4z_r <= aik_pkg::mul24(dz_r, k_r.gz4);
    end
  end

  // Doubling then dropping eight bits is one floor shift by seven.
  always_comb begin
    px = fx_r >>> 8;
    py = fy_r >>> 8;
    pz = fz_r >>> 8;
    cs = (qx_r + qy_r + qz_r) >>> 8;
    g1 = (g1x_r + g1y_r) >>> 7;
    g2 = (g2x_r + g2y_r + g2z_r) >>> 7;
    g3 = (g3x_r + g3y_r + g3z_r) >>> 7;
    g4 = (g4x_r + g4y_r + g4z_r) >>> 7;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x_r  <= sat_pos(px);
      pos_y_r  <= sat_pos(py);
      pos_z_r  <= sat_pos(pz);
      cost_r   <= (cs > 34'sd524287) ? 19'd524287 : cs[18:0];
      grad_1_r <= sat_grad(g1);
      grad_2_r <= sat_grad(g2);
      grad_3_r <= sat_grad(g3);
      grad_4_r <= sat_grad(g4);
    end
  end

  assign pos_x  = pos_x_r;
  assign pos_y  = pos_y_r;
  assign pos_z  = pos_z_r;
  assign cost   = cost_r;
  assign grad_1 = grad_1_r;
  assign grad_2 = grad_2_r;
  assign grad_3 = grad_3_r;
  assign grad_4 = grad_4_r;

endmodule

@@ design/arm_ik_cost_gradient_4dof.sv @@
// Top level of the four-joint arm cost and gradient pipeline.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   in       | in_valid, in_ready, in_joint_*, in_target_* | into block
//   out      | out_valid, out_ready, out_pos_*, out_cost,  | out of block
//            | out_grad_*                                  |
//   cfg      | cfg_we, cfg_index, cfg_data                 | into block
//
// One item per cycle enters unless out_ready stalls the pipeline; a result
// passes through the input registers, angle prep, the CORDIC with one
// rotation per stage (CORDIC_ITERATIONS capped at 24), kinematics and cost.
// Reset clears only the valid bits and presets links; no clearing pass.
// A stall on out_ready freezes every stage at once, so in_ready follows it and
// nothing is dropped or repeated.
module arm_ik_cost_gradient_4dof #(
  parameter int CORDIC_ITERATIONS = aik_pkg::CORDIC_ITER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_joint_1,
  input  logic signed [15:0] in_joint_2,
  input  logic signed [15:0] in_joint_3,
  input  logic signed [15:0] in_joint_4,
  input  logic signed [16:0] in_target_x,
  input  logic signed [16:0] in_target_y,
  input  logic signed [16:0] in_target_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_pos_x,
  output logic signed [16:0] out_pos_y,
  output logic signed [16:0] out_pos_z,
  output logic [18:0]        out_cost,
  output logic signed [19:0] out_grad_1,
  output logic signed [19:0] out_grad_2,
  output logic signed [19:0] out_grad_3,
  output logic signed [19:0] out_grad_4,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int NI  = (CORDIC_ITERATIONS > aik_pkg::CORDIC_ITER_MAX) ?
                       aik_pkg::CORDIC_ITER_MAX : CORDIC_ITERATIONS;
  // Targets wait out angle prep, CORDIC and kinematics.
  localparam int TD  = NI + 6;
  localparam int LAT = NI + 10;

  logic          en;
  logic          vld_r [LAT];
  logic [15:0]   l2_r, l3_r, l4_r, hb_r;
  aik_pkg::ang_t a_r [4];
  aik_pkg::tgt_t t_r;
  aik_pkg::tgt_t tdl_r [TD];
  aik_pkg::ang_t z   [4];
  logic          neg [4];
  aik_pkg::wide_t sn [4];
  aik_pkg::wide_t cn [4];
  aik_pkg::kin_t  kin;
  logic signed [17:0] s23, s234;

  // Whole pipeline advances together; the output register drains first.
  assign en       = !vld_r[LAT-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l2_r <= aik_pkg::UPPER_ARM_RST;
      l3_r <= aik_pkg::FOREARM_RST;
      l4_r <= aik_pkg::WRIST_RST;
      hb_r <= aik_pkg::BASE_H_RST;
    end else if (cfg_we) begin
      unique case (aik_pkg::cfg_reg_t'(cfg_index))
        aik_pkg::REG_UPPER_ARM: l2_r <= cfg_data;
        aik_pkg::REG_FOREARM:   l3_r <= cfg_data;
        aik_pkg::REG_WRIST:     l4_r <= cfg_data;
        aik_pkg::REG_BASE_H:    hb_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Cumulative pitch sums at 18 bits, then widened to Q30 without loss.
  assign s23  = 18'(in_joint_2) + 18'(in_joint_3);
  assign s234 = s23 + 18'(in_joint_4);

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= {{3{in_joint_1[15]}}, in_joint_1, 17'd0};
      a_r[1] <= {{3{in_joint_2[15]}}, in_joint_2, 17'd0};
      a_r[2] <= {{1{s23[17]}}, s23, 17'd0};
      a_r[3] <= {{1{s234[17]}}, s234, 17'd0};
      t_r.x  <= in_target_x;
      t_r.y  <= in_target_y;
      t_r.z  <= in_target_z;
      tdl_r[0] <= t_r;
      for (int i = 1; i < TD; i++) begin
        tdl_r[i] <= tdl_r[i-1];
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_trig
    aik_angle u_angle (
      .clk   (clk),
      .en    (en),
      .a_i   (a_r[k]),
      .z_o   (z[k]),
      .neg_o (neg[k])
    );
    aik_cordic #(.NI(NI)) u_cordic (
      .clk   (clk),
      .en    (en),
      .z_i   (z[k]),
      .neg_i (neg[k]),
      .sin_o (sn[k]),
      .cos_o (cn[k])
    );
  end

  aik_kin u_kin (
    .clk  (clk),
    .en   (en),
    .l2   (l2_r),
    .l3   (l3_r),
    .l4   (l4_r),
    .hb   (hb_r),
    .s1   (sn[0]),
    .c1   (cn[0]),
    .s2   (sn[1]),
    .c2   (cn[1]),
    .s23  (sn[2]),
    .c23  (cn[2]),
    .s234 (sn[3]),
    .c234 (cn[3]),
    .k_o  (kin)
  );

  aik_cost u_cost (
    .clk    (clk),
    .en     (en),
    .k_i    (kin),
    .t_i    (tdl_r[TD-1]),
    .pos_x  (out_pos_x),
    .pos_y  (out_pos_y),
    .pos_z  (out_pos_z),
    .cost   (out_cost),
    .grad_1 (out_grad_1),
    .grad_2 (out_grad_2),
    .grad_3 (out_grad_3),
    .grad_4 (out_grad_4)
  );

endmodule

@@ design/aik_checker.sv @@
// Port-level checks for the arm cost pipeline, bound to the top level.
module aik_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [18:0] out_cost
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cost))
    else $error("stalled result changed");

  // Accept input exactly when the output stage can advance.
  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready out of step with output stage");

  // Drop all results on reset.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind arm_ik_cost_gradient_4dof aik_checker u_aik_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_cost  (out_cost)
);

@@ tb/tb.sv @@
// Testbench for the four-joint arm cost and gradient pipeline.
`timescale 1ns / 1ps

module tb;

  localparam int ITERS     = 16;
  localparam int LATENCY   = ITERS + 10;
  localparam int RAND_ITEMS = 900;
  localparam int CYCLE_LIMIT = 400000;

  // Q30 angle constants and the CORDIC gain.
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30    = 64'sd652032874;

  typedef struct packed {
    logic signed [15:0] j1, j2, j3, j4;
    logic signed [16:0] tx, ty, tz;
  } pose_t;

  typedef struct packed {
    logic signed [16:0] px, py, pz;
    logic [18:0]        cost;
    logic signed [19:0] g1, g2, g3, g4;
  } kin_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_joint_1 = '0, in_joint_2 = '0, in_joint_3 = '0, in_joint_4 = '0;
  logic signed [16:0] in_target_x = '0, in_target_y = '0, in_target_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [16:0] out_pos_x, out_pos_y, out_pos_z;
  logic [18:0]        out_cost;
  logic signed [19:0] out_grad_1, out_grad_2, out_grad_3, out_grad_4;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  always #5 clk = ~clk;

  arm_ik_cost_gradient_4dof #(.CORDIC_ITERATIONS(ITERS)) dut (.*);

  // Link registers as the predictor sees them.
  logic [15:0] len_upper = aik_pkg::UPPER_ARM_RST;
  logic [15:0] len_fore  = aik_pkg::FOREARM_RST;
  logic [15:0] len_wrist = aik_pkg::WRIST_RST;
  logic [15:0] height_base = aik_pkg::BASE_H_RST;

  pose_t       pose_queue[$];
  kin_result_t expected_results[$];
  int          mismatch_count = 0;
  int          result_count = 0;
  longint      cycle_count = 0;
  bit          quiet_tail = 1'b0;
  bit          stim_done = 1'b0;

  function automatic longint atan_q30(int i);
    longint tab[24] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                        64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    return tab[i];
  endfunction

  // >>> on longint is arithmetic, which is the floor shift we need.
  function automatic longint q24_mul(longint a, longint b);
    return (a * b) >>> 24;
  endfunction

  // Rotation-mode CORDIC: Q30 angle in, Q24 sine and cosine out.
  task automatic rotate_q30(input longint ang, output longint s, output longint c);
    longint x, y, z, nx;
    bit flip;
    x = GAIN_Q30; y = 0; flip = 0;
    while (ang >= PI_Q30) ang -= TWO_PI_Q30;
    while (ang < -PI_Q30) ang += TWO_PI_Q30;
    if (ang > HALF_PI_Q30) begin
      ang -= PI_Q30; flip = 1;
    end else if (ang < -HALF_PI_Q30) begin
      ang += PI_Q30; flip = 1;
    end
    z = ang;
    for (int i = 0; i < ITERS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_q30(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_q30(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x >>> 6;
    s = y >>> 6;
  endtask

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic longint cost_slope(longint dx, longint dy, longint dz,
                                        longint gx, longint gy, longint gz);
    longint g;
    g = q24_mul(dx, gx) + q24_mul(dy, gy) + q24_mul(dz, gz);
    return clamp((2 * g) >>> 8, -524288, 524287);
  endfunction

  // Forward kinematics, squared error and its joint gradient for one pose.
  task automatic predict_pose(input pose_t p, output kin_result_t r);
    longint a1, a2, a3, a4, tx, ty, tz, l2, l3, l4, hb;
    longint s1, c1, s2, c2, s23, c23, s234, c234;
    longint a2c, a3c, a4c, a2s, a3s, a4s, rad, hgt, fx, fy, fz, dx, dy, dz, cst;
    a1 = longint'(p.j1) * 131072; a2 = longint'(p.j2) * 131072;
    a3 = longint'(p.j3) * 131072; a4 = longint'(p.j4) * 131072;
    tx = longint'(p.tx) * 256; ty = longint'(p.ty) * 256; tz = longint'(p.tz) * 256;
    l2 = longint'(len_upper) * 256; l3 = longint'(len_fore) * 256;
    l4 = longint'(len_wrist) * 256; hb = longint'(height_base) * 256;
    rotate_q30(a1, s1, c1);
    rotate_q30(a2, s2, c2);
    rotate_q30(a2 + a3, s23, c23);
    rotate_q30(a2 + a3 + a4, s234, c234);
    a2c = q24_mul(l2, c2); a3c = q24_mul(l3, c23); a4c = q24_mul(l4, c234);
    a2s = q24_mul(l2, s2); a3s = q24_mul(l3, s23); a4s = q24_mul(l4, s234);
    rad = a4c + a3c + a2c;
    hgt = a4s + a3s + a2s;
    fx = q24_mul(c1, rad); fy = q24_mul(s1, rad); fz = hb + hgt;
    dx = fx - tx; dy = fy - ty; dz = fz - tz;
    cst = q24_mul(dx, dx) + q24_mul(dy, dy) + q24_mul(dz, dz);
    r.px   = 17'(clamp(fx >>> 8, -65536, 65535));
    r.py   = 17'(clamp(fy >>> 8, -65536, 65535));
    r.pz   = 17'(clamp(fz >>> 8, -65536, 65535));
    r.cost = 19'(clamp(cst >>> 8, 0, 524287));
    r.g1 = 20'(cost_slope(dx, dy, dz, -fy, fx, 0));
    r.g2 = 20'(cost_slope(dx, dy, dz, q24_mul(c1, -hgt), q24_mul(s1, -hgt), rad));
    r.g3 = 20'(cost_slope(dx, dy, dz, q24_mul(c1, -(a4s + a3s)),
                          q24_mul(s1, -(a4s + a3s)), a4c + a3c));
    r.g4 = 20'(cost_slope(dx, dy, dz, q24_mul(c1, -a4s), q24_mul(s1, -a4s), a4c));
  endtask

  // Driver: present queued poses, with random idle bursts.
  int send_gap = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        kin_result_t r;
        predict_pose(pose_queue.pop_front(), r);
        expected_results.push_back(r);
      end
      if (in_valid && !in_ready) begin
        // hold the pending transfer
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(1, 16) - 1;
        in_valid <= 1'b0;
      end else begin
        // the head of the queue after a possible pop above
        if (pose_queue.size() > 0) begin
          pose_t p;
          p = pose_queue[0];
          in_valid <= 1'b1;
          {in_joint_1, in_joint_2, in_joint_3, in_joint_4} <= {p.j1, p.j2, p.j3, p.j4};
          {in_target_x, in_target_y, in_target_z} <= {p.tx, p.ty, p.tz};
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        kin_result_t got, want;
        got = '{out_pos_x, out_pos_y, out_pos_z, out_cost,
                out_grad_1, out_grad_2, out_grad_3, out_grad_4};
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("unexpected result transfer %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      // back-pressure in bursts
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(1, 16) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic pose_t random_pose();
    pose_t p;
    p.j1 = 16'($urandom); p.j2 = 16'($urandom);
    p.j3 = 16'($urandom); p.j4 = 16'($urandom);
    // mostly reachable targets, sometimes the full range
    if ($urandom_range(0, 3) == 0) begin
      p.tx = 17'($urandom); p.ty = 17'($urandom); p.tz = 17'($urandom);
    end else begin
      p.tx = 17'($signed($urandom_range(0, 40000)) - 20000);
      p.ty = 17'($signed($urandom_range(0, 40000)) - 20000);
      p.tz = 17'($signed($urandom_range(0, 40000)) - 10000);
    end
    return p;
  endfunction

  // Wait for every prediction to drain, then for the pipeline to empty.
  task automatic drain();
    wait (pose_queue.size() == 0 && !in_valid);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input aik_pkg::cfg_reg_t idx, input logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      aik_pkg::REG_UPPER_ARM: len_upper   = val;
      aik_pkg::REG_FOREARM:   len_fore    = val;
      aik_pkg::REG_WRIST:     len_wrist   = val;
      aik_pkg::REG_BASE_H:    height_base = val;
    endcase
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) pose_queue.push_back(random_pose());
  endtask

  initial begin
    logic signed [15:0] jv[5] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh3244, -16'sh3244};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: angle extremes, folds past half pi, target extremes.
    foreach (jv[i]) pose_queue.push_back('{jv[i], jv[i], jv[i], jv[i], '0, '0, '0});
    pose_queue.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                           17'sh0FFFF, 17'sh0FFFF, 17'sh0FFFF});
    pose_queue.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                           -17'sh10000, -17'sh10000, -17'sh10000});
    pose_queue.push_back('{'0, 16'sh1922, 16'sh1922, 16'sh1922, -17'sh10000, 17'sh0FFFF, '0});
    pose_queue.push_back('{16'sh1922, 16'shE6DE, 16'sh0001, 16'shFFFF, '0, '0, -17'sh10000});
    queue_random(150);
    drain();

    // Largest links and height: internal position beyond the output range.
    write_reg(aik_pkg::REG_UPPER_ARM, 16'hFFFF);
    write_reg(aik_pkg::REG_FOREARM, 16'hFFFF);
    write_reg(aik_pkg::REG_WRIST, 16'hFFFF);
    write_reg(aik_pkg::REG_BASE_H, 16'hFFFF);
    pose_queue.push_back('{'0, '0, '0, '0, -17'sh10000, -17'sh10000, -17'sh10000});
    pose_queue.push_back('{'0, 16'sh3244, '0, '0, 17'sh0FFFF, 17'sh0FFFF, -17'sh10000});
    queue_random(150);
    drain();

    // Zero-length arm.
    write_reg(aik_pkg::REG_UPPER_ARM, 16'h0000);
    write_reg(aik_pkg::REG_FOREARM, 16'h0000);
    write_reg(aik_pkg::REG_WRIST, 16'h0000);
    write_reg(aik_pkg::REG_BASE_H, 16'h0000);
    queue_random(150);
    drain();

    // Random link settings.
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(aik_pkg::REG_UPPER_ARM, 16'($urandom));
      write_reg(aik_pkg::REG_FOREARM, 16'($urandom));
      write_reg(aik_pkg::REG_WRIST, 16'($urandom));
      write_reg(aik_pkg::REG_BASE_H, 16'($urandom));
      queue_random(100);
      drain();
    end

    // Back to reset values, last stretch without idling.
    write_reg(aik_pkg::REG_UPPER_ARM, aik_pkg::UPPER_ARM_RST);
    write_reg(aik_pkg::REG_FOREARM, aik_pkg::FOREARM_RST);
    write_reg(aik_pkg::REG_WRIST, aik_pkg::WRIST_RST);
    write_reg(aik_pkg::REG_BASE_H, aik_pkg::BASE_H_RST);
    quiet_tail = 1'b1;
    queue_random(150);
    drain();

    $display("covered %0d result transfers over seven link setting phases,", result_count);
    $display("including zero and full-scale links and all angle and target extremes");
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/aik_pkg.sv
design/aik_angle.sv
design/aik_cordic.sv
design/aik_kin.sv
design/aik_cost.sv
design/arm_ik_cost_gradient_4dof.sv
design/aik_checker.sv
tb/tb.sv
